@@ hw/rtl/rau_pkg.sv @@
// Rational arithmetic unit package: word types, commands, status codes, sequencer states.
// Depends on nothing; used by every file of the block.
`timescale 1ns / 1ps
package rau_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int WIDE_BITS     = 64;

    typedef enum logic [2:0] {
        CMD_NORM = 3'd0,
        CMD_ADD  = 3'd1,
        CMD_SUB  = 3'd2,
        CMD_MUL  = 3'd3,
        CMD_DIV  = 3'd4,
        CMD_EQ   = 3'd5,
        CMD_LT   = 3'd6,
        CMD_NONE = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZDEN = 2'd1,
        ST_DIVZ = 2'd2,
        ST_OVF  = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic               compare_flag;
        logic [1:0]         status;
    } out_word_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RED_A,
        S_RED_B,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_MUL4,
        S_COMB,
        S_RED_R,
        S_DONE
    } state_t;

    // Handshake between sequencer and gcd reducer.
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } red_ctl_t;

endpackage

@@ hw/rtl/rau_reduce.sv @@
// Reducer: divides a magnitude pair by its gcd, binary gcd then restoring division.
// Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_reduce
    import rau_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [WIDE_BITS-1:0]   n_in,
    input  logic [WIDE_BITS-1:0]   d_in,
    output red_ctl_t               ctl,
    output logic [WIDE_BITS-1:0]   n_out,
    output logic [WIDE_BITS-1:0]   d_out
);

    localparam int CW = $clog2(WIDE_BITS + 1);

    typedef enum logic [2:0] {R_IDLE, R_SHIFT, R_GCD, R_DIVN, R_DIVD, R_DONE} rstate_t;

    rstate_t              st_reg, st_next;
    logic [WIDE_BITS-1:0] x_reg, x_next, y_reg, y_next;
    logic [WIDE_BITS-1:0] n_reg, n_next, d_reg, d_next;
    logic [WIDE_BITS-1:0] g_reg, g_next;
    logic [WIDE_BITS-1:0] q_reg, q_next, rem_reg, rem_next;
    logic [CW-1:0]        k_reg, k_next;
    logic [CW-1:0]        i_reg, i_next;
    logic [WIDE_BITS:0]   trial;
    logic [WIDE_BITS-1:0] dsrc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= R_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        n_reg   <= n_next;
        d_reg   <= d_next;
        g_reg   <= g_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        k_reg   <= k_next;
        i_reg   <= i_next;
    end

    assign dsrc  = (st_reg == R_DIVN) ? n_reg : d_reg;
    assign trial = {rem_reg, dsrc[i_reg[CW-2:0]]} - {1'b0, g_reg};

    always_comb
    begin
        st_next  = st_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        n_next   = n_reg;
        d_next   = d_reg;
        g_next   = g_reg;
        q_next   = q_reg;
        rem_next = rem_reg;
        k_next   = k_reg;
        i_next   = i_reg;
        case (st_reg)
            R_IDLE:
            begin
                if (start)
                begin
                    x_next  = n_in;
                    y_next  = d_in;
                    n_next  = n_in;
                    d_next  = d_in;
                    k_next  = '0;
                    st_next = R_SHIFT;
                end
            end
            R_SHIFT:
            begin
                // strip common factors of two, both operands nonzero
                if (!x_reg[0] && !y_reg[0])
                begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
                else
                begin
                    st_next = R_GCD;
                end
            end
            R_GCD:
            begin
                if (!x_reg[0])
                begin
                    x_next = x_reg >> 1;
                end
                else if (!y_reg[0])
                begin
                    y_next = y_reg >> 1;
                end
                else if (x_reg == y_reg)
                begin
                    g_next   = x_reg << k_reg;
                    rem_next = '0;
                    q_next   = '0;
                    i_next   = CW'(WIDE_BITS - 1);
                    st_next  = R_DIVN;
                end
                else if (x_reg > y_reg)
                begin
                    x_next = (x_reg - y_reg) >> 1;
                end
                else
                begin
                    y_next = (y_reg - x_reg) >> 1;
                end
            end
            R_DIVN, R_DIVD:
            begin
                if (!trial[WIDE_BITS])
                begin
                    rem_next = trial[WIDE_BITS-1:0];
                    q_next   = {q_reg[WIDE_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[WIDE_BITS-2:0], dsrc[i_reg[CW-2:0]]};
                    q_next   = {q_reg[WIDE_BITS-2:0], 1'b0};
                end
                if (i_reg == '0)
                begin
                    if (st_reg == R_DIVN)
                    begin
                        n_next  = q_next;
                        st_next = R_DIVD;
                    end
                    else
                    begin
                        d_next  = q_next;
                        st_next = R_DONE;
                    end
                    rem_next = '0;
                    q_next   = '0;
                    i_next   = CW'(WIDE_BITS - 1);
                end
                else
                begin
                    i_next = i_reg - 1'b1;
                end
            end
            R_DONE:
            begin
                st_next = R_IDLE;
            end
            default:
            begin
                st_next = R_IDLE;
            end
        endcase
    end

    assign ctl.start = start;
    assign ctl.busy  = (st_reg != R_IDLE);
    assign ctl.done  = (st_reg == R_DONE);
    assign n_out     = n_reg;
    assign d_out     = d_reg;

endmodule

@@ hw/rtl/rational_arithmetic_unit.sv @@
// Top level of the rational arithmetic unit: sequencer, shared multiplier, result register.
// Depends on rau_pkg and rau_reduce.
`timescale 1ns / 1ps
// Usage: drive the input word and raise start while busy is low; the word is taken at
// that edge and busy rises the cycle after. One result word appears on result for a
// single cycle with valid high, then busy falls. The receiver cannot stall; the word
// must be captured in the cycle that valid is high.
// Sequence: each operand reduction runs a binary gcd on 31-bit magnitudes then two
// restoring divisions in the shared reducer; a further reduction on 64-bit values
// follows for arithmetic commands. Three steps of the shared 32x32 multiplier form
// cross products and a fourth settles compares and divide by zero. A zero or faulty
// operand skips its reduction. Words are handled one at a time.
// Reset clears the sequencer to idle with no result pending.
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_word_t  operands,
    output logic      busy,
    output logic      valid,
    output out_word_t result
);

    localparam logic [WIDE_BITS-1:0] VMAX = (WIDE_BITS'(1) << (WORD_BITS - 1)) - 1'b1;

    state_t               st_reg, st_next;
    in_word_t             in_reg;
    logic                 load;
    logic [WIDE_BITS-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic                 as_reg, bs_reg;
    logic signed [WIDE_BITS-1:0] p_reg [3];
    logic signed [WIDE_BITS-1:0] rn_reg, rd_reg;
    logic                 rs_reg;
    logic [1:0]           stat_reg;
    logic                 flag_reg;
    out_word_t            out_reg;
    logic                 valid_reg;

    logic                 red_start;
    logic [WIDE_BITS-1:0] red_n, red_d, red_qn, red_qd;
    red_ctl_t             red_ctl;

    logic signed [WIDE_BITS-1:0] san, sad, sbn, sbd, ma, mb, sum_v, num_v, den_v;
    logic signed [WIDE_BITS-1:0] mul_res;
    logic [1:0]           stat_a, stat_b;
    logic [2:0]           cmd;

    function automatic logic [WIDE_BITS-1:0] mag64(input logic signed [WIDE_BITS-1:0] v);
        mag64 = v[WIDE_BITS-1] ? WIDE_BITS'(-v) : WIDE_BITS'(v);
    endfunction

    function automatic logic [1:0] chk(input logic signed [31:0] n,
                                       input logic signed [31:0] d);
        logic [WIDE_BITS-1:0] mn, md;
        mn = mag64(WIDE_BITS'(n));
        md = mag64(WIDE_BITS'(d));
        if (mn > VMAX || md > VMAX)
            chk = ST_OVF;
        else if (n != 0 && d == 0)
            chk = ST_ZDEN;
        else
            chk = ST_OK;
    endfunction

    assign cmd    = in_reg.command;
    assign stat_a = chk(in_reg.a_num, in_reg.a_den);
    assign stat_b = chk(in_reg.b_num, in_reg.b_den);
    assign load   = start && !busy;

    assign san = as_reg ? -$signed(an_reg) : $signed(an_reg);
    assign sad = $signed(ad_reg);
    assign sbn = bs_reg ? -$signed(bn_reg) : $signed(bn_reg);
    assign sbd = $signed(bd_reg);

    // shared multiplier operand select
    always_comb
    begin
        ma = san;
        mb = sbd;
        case (st_reg)
            S_MUL1:  begin ma = san; mb = (cmd == CMD_MUL) ? sbn : sbd; end
            S_MUL2:  begin ma = sbn; mb = sad; end
            S_MUL3:  begin ma = sad; mb = (cmd == CMD_DIV) ? sbn : sbd; end
            default: begin ma = san; mb = sbd; end
        endcase
    end
    assign mul_res = $signed(ma[31:0]) * $signed(mb[31:0]);

    always_comb
    begin
        sum_v = (cmd == CMD_SUB) ? p_reg[0] - p_reg[1] : p_reg[0] + p_reg[1];
        num_v = sum_v;
        den_v = p_reg[2];
        case (cmd)
            CMD_MUL: begin num_v = p_reg[0]; den_v = p_reg[2]; end
            CMD_DIV: begin num_v = p_reg[0]; den_v = p_reg[2]; end
            default: begin num_v = sum_v;    den_v = p_reg[2]; end
        endcase
        if (den_v[WIDE_BITS-1])
        begin
            num_v = -num_v;
            den_v = -den_v;
        end
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE:  if (load) st_next = S_RED_A;
            S_RED_A:
            begin
                if (stat_a != ST_OK || cmd == CMD_NONE)
                    st_next = S_DONE;
                else if (in_reg.a_num == 0)
                    st_next = (cmd == CMD_NORM) ? S_DONE : S_RED_B;
                else if (red_ctl.done)
                    st_next = (cmd == CMD_NORM) ? S_DONE : S_RED_B;
            end
            S_RED_B:
            begin
                if (stat_b != ST_OK)
                    st_next = S_DONE;
                else if (in_reg.b_num == 0 || red_ctl.done)
                    st_next = S_MUL1;
            end
            S_MUL1:  st_next = S_MUL2;
            S_MUL2:  st_next = S_MUL3;
            S_MUL3:  st_next = S_MUL4;
            S_MUL4:  st_next = S_COMB;
            S_COMB:
            begin
                if (cmd == CMD_EQ || cmd == CMD_LT || stat_reg != ST_OK || num_v == 0)
                    st_next = S_DONE;
                else
                    st_next = S_RED_R;
            end
            S_RED_R: if (red_ctl.done) st_next = S_DONE;
            S_DONE:  st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        red_start = 1'b0;
        red_n     = mag64(WIDE_BITS'(in_reg.a_num));
        red_d     = mag64(WIDE_BITS'(in_reg.a_den));
        case (st_reg)
            S_RED_A:
            begin
                red_n     = mag64(WIDE_BITS'(in_reg.a_num));
                red_d     = mag64(WIDE_BITS'(in_reg.a_den));
                red_start = !red_ctl.busy && stat_a == ST_OK && in_reg.a_num != 0
                            && cmd != CMD_NONE;
            end
            S_RED_B:
            begin
                red_n     = mag64(WIDE_BITS'(in_reg.b_num));
                red_d     = mag64(WIDE_BITS'(in_reg.b_den));
                red_start = !red_ctl.busy && stat_b == ST_OK && in_reg.b_num != 0;
            end
            S_RED_R:
            begin
                red_n     = mag64(rn_reg);
                red_d     = WIDE_BITS'(rd_reg);
                red_start = !red_ctl.busy && !red_ctl.done;
            end
            default:
            begin
                red_start = 1'b0;
            end
        endcase
    end

    rau_reduce u_reduce (
        .clk   (clk),
        .rst_n (rst_n),
        .start (red_start),
        .n_in  (red_n),
        .d_in  (red_d),
        .ctl   (red_ctl),
        .n_out (red_qn),
        .d_out (red_qd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            valid_reg <= (st_reg == S_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            in_reg   <= operands;
            stat_reg <= ST_OK;
            flag_reg <= 1'b0;
            an_reg   <= '0;
            ad_reg   <= WIDE_BITS'(1);
            bn_reg   <= '0;
            bd_reg   <= WIDE_BITS'(1);
            as_reg   <= 1'b0;
            bs_reg   <= 1'b0;
            rs_reg   <= 1'b0;
        end
        case (st_reg)
            S_RED_A:
            begin
                if (stat_a != ST_OK && cmd != CMD_NONE)
                    stat_reg <= stat_a;
                else if (red_ctl.done)
                begin
                    an_reg <= red_qn;
                    ad_reg <= red_qd;
                    as_reg <= in_reg.a_num[31] ^ in_reg.a_den[31];
                end
            end
            S_RED_B:
            begin
                if (stat_b != ST_OK)
                    stat_reg <= stat_b;
                else if (red_ctl.done)
                begin
                    bn_reg <= red_qn;
                    bd_reg <= red_qd;
                    bs_reg <= in_reg.b_num[31] ^ in_reg.b_den[31];
                end
            end
            S_MUL1: p_reg[0] <= mul_res;
            S_MUL2: p_reg[1] <= mul_res;
            S_MUL3: p_reg[2] <= mul_res;
            S_MUL4:
            begin
                if (cmd == CMD_DIV && bn_reg == 0)
                    stat_reg <= ST_DIVZ;
                if (cmd == CMD_EQ)
                    flag_reg <= (san == sbn) && (ad_reg == bd_reg);
                if (cmd == CMD_LT)
                    flag_reg <= (p_reg[0] < p_reg[1]);
            end
            S_COMB:
            begin
                rn_reg <= num_v;
                rd_reg <= den_v;
                rs_reg <= num_v[WIDE_BITS-1];
            end
            S_RED_R:
            begin
                if (red_ctl.done)
                begin
                    rn_reg <= rs_reg ? -$signed(red_qn) : $signed(red_qn);
                    rd_reg <= $signed(red_qd);
                end
            end
            default:
            begin
            end
        endcase
    end

    // S_COMB reads rn_reg before it is written; use num_v for the zero test there
    always_ff @(posedge clk)
    begin
        if (st_reg == S_DONE)
        begin
            if (stat_reg != ST_OK)
            begin
                out_reg <= '{res_num: '0, res_den: 31'd1, compare_flag: 1'b0, status: stat_reg};
            end
            else if (cmd == CMD_NORM)
            begin
                out_reg <= '{res_num: 32'(san), res_den: 31'(ad_reg),
                             compare_flag: 1'b0, status: ST_OK};
            end
            else if (cmd == CMD_EQ || cmd == CMD_LT)
            begin
                out_reg <= '{res_num: '0, res_den: 31'd1, compare_flag: flag_reg,
                             status: ST_OK};
            end
            else if (cmd == CMD_NONE || rn_reg == 0)
            begin
                out_reg <= '{res_num: '0, res_den: 31'd1, compare_flag: 1'b0, status: ST_OK};
            end
            else if (mag64(rn_reg) > VMAX || WIDE_BITS'(rd_reg) > VMAX)
            begin
                out_reg <= '{res_num: '0, res_den: 31'd1, compare_flag: 1'b0, status: ST_OVF};
            end
            else
            begin
                out_reg <= '{res_num: 32'(rn_reg), res_den: 31'(rd_reg),
                             compare_flag: 1'b0, status: ST_OK};
            end
        end
    end

    assign busy   = (st_reg != S_IDLE) || valid_reg;
    assign valid  = valid_reg;
    assign result = out_reg;

    a_valid_one: assert property (@(posedge clk) disable iff (!rst_n)
        valid |=> !valid) else $error("result strobe longer than one cycle");
    a_busy_valid: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> busy) else $error("result shown while idle");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && result.status != ST_OK |-> result.res_num == 0 && result.res_den == 31'd1)
        else $error("error result not cleared");

endmodule
